// ----- rtl/hfl_pkg.sv -----
// shared types and constants for the handle table with free list
// no dependencies; imported by the slot ram, the engine and the top level

package hfl_pkg;

   localparam int HANDLE_BITS         = 16;
   localparam int OBJ_FIELD_BITS      = 64;
   localparam int DEFAULT_CAPACITY    = 256;
   localparam int DEFAULT_OBJECT_BITS = 64;

   typedef enum logic [1:0] {
      CMD_GET    = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOT_LIVE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // memory port control between engine and slot ram
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } mem_ctl_type;

endpackage

// ----- rtl/hfl_slot_ram.sv -----
// slot table: one synchronous memory, one write and one read port, registered read
// depends on hfl_pkg for the control struct

module hfl_slot_ram #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8,
   parameter int DATA_W = 66
) (
   input  logic                 clock,
   input  hfl_pkg::mem_ctl_type ctl,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [DATA_W-1:0]    rd_data
);
   import hfl_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/hfl_engine.sv -----
// command sequencer: reads a slot, updates the free list and allocation mark,
// writes the slot back and loads the result register; uses hfl_pkg

module hfl_engine #(
   parameter int CAPACITY    = 256,
   parameter int OBJECT_BITS = 64,
   parameter int IDX_W       = 8,
   parameter int MARK_W      = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_cmd,
   input  logic [hfl_pkg::HANDLE_BITS-1:0]  req_handle,
   input  logic [OBJECT_BITS-1:0]           req_object,
   input  logic                             req_inherit,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [hfl_pkg::HANDLE_BITS-1:0]  rsp_handle,
   output logic [OBJECT_BITS-1:0]           rsp_object,
   output hfl_pkg::mem_ctl_type             mem_ctl,
   output logic [IDX_W-1:0]                 mem_wr_addr,
   output logic [OBJECT_BITS+1:0]           mem_wr_data,
   output logic [IDX_W-1:0]                 mem_rd_addr,
   input  logic [OBJECT_BITS+1:0]           mem_rd_data
);
   import hfl_pkg::*;

   localparam int CMP_W  = (MARK_W > HANDLE_BITS) ? MARK_W : HANDLE_BITS;
   localparam int LINK_W = (MARK_W > OBJECT_BITS) ? MARK_W : OBJECT_BITS;

   state_type              state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [OBJECT_BITS-1:0] obj_ff, obj_in;
   logic                   inh_ff, inh_in;
   logic [MARK_W-1:0]      used_mark_ff, used_mark_in;
   logic [IDX_W-1:0]       free_head_ff, free_head_in;
   logic                   free_valid_ff, free_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [OBJECT_BITS-1:0] rsp_obj_ff, rsp_obj_in;

   logic                   accept;
   logic                   can_finish;
   logic [OBJECT_BITS-1:0] rd_obj;
   logic                   rd_free;
   logic                   rd_inh;
   logic                   live;
   logic                   pop_ok;
   logic                   link_end;
   logic                   room;
   logic [IDX_W-1:0]       ins_slot;
   logic [OBJECT_BITS-1:0] link_val;

   assign req_ready  = (state_ff == S_IDLE);
   assign accept     = req_valid && req_ready;
   assign can_finish = !rsp_valid_ff || rsp_ready;

   assign rd_obj  = mem_rd_data[OBJECT_BITS-1:0];
   assign rd_free = mem_rd_data[OBJECT_BITS];
   assign rd_inh  = mem_rd_data[OBJECT_BITS+1];

   // live: below the used mark and not on the free list
   assign live     = (CMP_W'(handle_ff) < CMP_W'(used_mark_ff)) && !rd_free;
   assign pop_ok   = free_valid_ff && (MARK_W'(free_head_ff) < used_mark_ff);
   assign link_end = (LINK_W'(rd_obj) == LINK_W'(free_head_ff)) ||
                     (LINK_W'(rd_obj) >= LINK_W'(used_mark_ff));
   assign room     = used_mark_ff < MARK_W'(CAPACITY);
   assign ins_slot = pop_ok ? free_head_ff : used_mark_ff[IDX_W-1:0];
   assign link_val = free_valid_ff ? OBJECT_BITS'(free_head_ff) : OBJECT_BITS'(handle_ff);

   assign mem_rd_addr   = (req_cmd == CMD_INSERT) ? free_head_ff : req_handle[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      obj_in        = obj_ff;
      inh_in        = inh_ff;
      used_mark_in  = used_mark_ff;
      free_head_in  = free_head_ff;
      free_valid_in = free_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_obj_in    = rsp_obj_ff;
      // slot read is issued with the accepted word
      mem_ctl.rd_en = accept;
      mem_ctl.wr_en = 1'b0;
      mem_wr_addr   = handle_ff[IDX_W-1:0];
      mem_wr_data   = mem_rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_EXEC;
               cmd_in    = req_cmd;
               handle_in = req_handle;
               obj_in    = req_object;
               inh_in    = req_inherit;
            end
         end
         S_EXEC: begin
            if (can_finish) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_LIVE;
               rsp_handle_in = '0;
               rsp_obj_in    = '0;
               case (cmd_ff)
                  CMD_GET: begin
                     if (live) begin
                        rsp_status_in = ST_OK;
                        rsp_obj_in    = rd_obj;
                     end
                  end
                  CMD_INSERT: begin
                     if (pop_ok || room) begin
                        if (pop_ok) begin
                           if (link_end) begin
                              free_valid_in = 1'b0;
                              free_head_in  = '0;
                           end else begin
                              free_head_in = IDX_W'(rd_obj);
                           end
                        end else begin
                           free_valid_in = 1'b0;
                           used_mark_in  = used_mark_ff + MARK_W'(1);
                        end
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = ins_slot;
                        mem_wr_data   = {inh_ff, 1'b0, obj_ff};
                        rsp_status_in = ST_OK;
                        rsp_handle_in = HANDLE_BITS'(ins_slot);
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  CMD_REMOVE: begin
                     if (live) begin
                        mem_ctl.wr_en = 1'b1;
                        mem_wr_addr   = handle_ff[IDX_W-1:0];
                        mem_wr_data   = {rd_inh, 1'b1, link_val};
                        free_head_in  = handle_ff[IDX_W-1:0];
                        free_valid_in = 1'b1;
                        rsp_status_in = ST_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_mark_ff  <= '0;
         free_head_ff  <= '0;
         free_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_mark_ff  <= used_mark_in;
         free_head_ff  <= free_head_in;
         free_valid_ff <= free_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      handle_ff     <= handle_in;
      obj_ff        <= obj_in;
      inh_ff        <= inh_in;
      rsp_status_ff <= rsp_status_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_obj_ff    <= rsp_obj_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_object = rsp_obj_ff;

`ifndef SYNTH
   a_head_below_mark: assert property (@(posedge clock) disable iff (reset)
      free_valid_ff |-> (MARK_W'(free_head_ff) < used_mark_ff))
      else $error("free list head at or above used mark");

   a_mark_bounded: assert property (@(posedge clock) disable iff (reset)
      used_mark_ff <= MARK_W'(CAPACITY))
      else $error("used mark beyond capacity");

   a_mark_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (used_mark_ff >= $past(used_mark_ff)))
      else $error("used mark went down");

   a_write_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (state_ff == S_EXEC) && can_finish && !mem_ctl.rd_en)
      else $error("slot write outside the update cycle");

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted word did not enter the update cycle");
`endif

endmodule

// ----- rtl/handle_table_free_list.sv -----
// handle table with free list, top level: stream ports, word packing, engine and slot ram
// depends on hfl_pkg, hfl_slot_ram and hfl_engine

// Hands out handles for object words over a table of CAPACITY slots. Each request word
// (get, insert, remove) yields exactly one response word. Insert reuses the most recently
// freed slot first, popping a free list threaded through the stored words of free slots,
// then takes the next never-used slot, and answers full when neither exists. Get and
// remove answer not-live for a handle that is free or not below the used mark; an unused
// command code also answers not-live and changes nothing. For each word the accept cycle
// issues the read of the slot memory, and the update state that follows updates the free
// list and used mark, writes the slot back and loads the response register. A
// request may be accepted while the previous response still waits; the update cycle
// stretches for as long as the response register is held by the consumer. No clearing
// pass is needed after reset: only slots below the used mark are ever consulted.
module handle_table_free_list #(
   parameter int CAPACITY    = hfl_pkg::DEFAULT_CAPACITY,
   parameter int OBJECT_BITS = hfl_pkg::DEFAULT_OBJECT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // handle[15:0], object[79:16], inherit[80], zero pad
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // new_handle[15:0], found_object[79:16]
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import hfl_pkg::*;

   // slot index and used-mark widths
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int MARK_W = $clog2(CAPACITY + 1);
   // slot word: inherit, free flag, object or link
   localparam int SLOT_W = OBJECT_BITS + 2;

   logic [HANDLE_BITS-1:0]   req_handle;
   logic [OBJ_FIELD_BITS-1:0] req_object;
   logic                     req_inherit;
   logic [HANDLE_BITS-1:0]   rsp_handle;
   logic [OBJECT_BITS-1:0]   rsp_object;

   mem_ctl_type              mem_ctl;
   logic [IDX_W-1:0]         mem_wr_addr;
   logic [SLOT_W-1:0]        mem_wr_data;
   logic [IDX_W-1:0]         mem_rd_addr;
   logic [SLOT_W-1:0]        mem_rd_data;

   // unpack the request word
   assign req_handle  = req_tdata[15:0];
   assign req_object  = req_tdata[79:16];
   assign req_inherit = req_tdata[80];

   hfl_engine #(
      .CAPACITY    (CAPACITY),
      .OBJECT_BITS (OBJECT_BITS),
      .IDX_W       (IDX_W),
      .MARK_W      (MARK_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_handle  (req_handle),
      // object is kept to OBJECT_BITS bits
      .req_object  (req_object[OBJECT_BITS-1:0]),
      .req_inherit (req_inherit),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_handle  (rsp_handle),
      .rsp_object  (rsp_object),
      .mem_ctl     (mem_ctl),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   hfl_slot_ram #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W),
      .DATA_W (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // pack the response word, object zero-extended to the field width
   assign rsp_tdata = {OBJ_FIELD_BITS'(rsp_object), rsp_handle};

endmodule
